[hdl/pfrt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the page fault residency tracker.
// No dependencies; used by pfrt_bitmap, pfrt_walk and the top level.
package pfrt_pkg;

    // Default width of a page index (bitmap holds 2^PAGE_INDEX_BITS pages)
    localparam int PAGE_INDEX_BITS_DEF = 16;

    // Bitmap row geometry: one row holds 64 residency bits
    localparam int ROW_SEL  = 6;
    localparam int ROW_BITS = 1 << ROW_SEL;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int SHIFT_W  = 5;
    localparam int PPF_W    = 7;
    localparam int BFLT_W   = 17;
    localparam int TOTAL_W  = 32;
    localparam int SUM_W    = ADDR_W + 2;
    localparam int CFG_DW   = 7;
    localparam int CFG_AW   = 1;
    localparam int IN_TDW   = 64;
    localparam int OUT_TDW  = 56;

    // Register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_PAGE_SHIFT = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_PPF        = 1'd1;

    // Register reset values and legal ranges
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
    localparam logic [PPF_W-1:0]   PPF_RST   = 7'd1;
    localparam logic [PPF_W-1:0]   PPF_MIN   = 7'd1;
    localparam logic [PPF_W-1:0]   PPF_MAX   = 7'd64;

    // One result beat
    typedef struct packed {
        logic                 out_of_range;
        logic [TOTAL_W-1:0]   total_faults;
        logic [BFLT_W-1:0]    block_faults;
    } res_t;

endpackage

[hdl/pfrt_bitmap.sv]
`timescale 1ns / 1ps
// Residency bitmap storage: simple dual-port RAM of 64-bit rows.
// One write and one read per cycle, read data registered. Uses pfrt_pkg.
module pfrt_bitmap #(
    parameter int ROW_AW = pfrt_pkg::PAGE_INDEX_BITS_DEF - pfrt_pkg::ROW_SEL
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ROW_AW-1:0]             wr_addr,
    input  logic [pfrt_pkg::ROW_BITS-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ROW_AW-1:0]             rd_addr,
    output logic [pfrt_pkg::ROW_BITS-1:0] rd_data
);

    logic [pfrt_pkg::ROW_BITS-1:0] mem [(1 << ROW_AW)];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/pfrt_walk.sv]
`timescale 1ns / 1ps
// Page walk sequencer: clears the bitmap after reset, then walks the pages of
// each block with read-modify-write on pfrt_bitmap. Uses pfrt_pkg.
module pfrt_walk #(
    parameter int PAGE_INDEX_BITS = pfrt_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pfrt_pkg::ADDR_W-1:0]        in_start,
    input  logic [pfrt_pkg::ADDR_W-1:0]        in_size,
    input  logic [pfrt_pkg::SHIFT_W-1:0]       page_shift,
    input  logic [pfrt_pkg::PPF_W-1:0]         pages_per_fault,
    output logic                               res_valid,
    input  logic                               res_ack,
    output pfrt_pkg::res_t                     res
);

    localparam int ROW_AW = PAGE_INDEX_BITS - pfrt_pkg::ROW_SEL;
    localparam int PAGE_W = PAGE_INDEX_BITS + 1;
    localparam logic [PAGE_W-1:0] MAP_PAGES = {1'b1, {PAGE_INDEX_BITS{1'b0}}};
    localparam logic [ROW_AW-1:0] LAST_ROW  = {ROW_AW{1'b1}};

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CALC     = 3'd2;
    localparam logic [2:0] S_PROBE    = 3'd3;
    localparam logic [2:0] S_CHECK    = 3'd4;
    localparam logic [2:0] S_SPILL_RD = 3'd5;
    localparam logic [2:0] S_SPILL_WR = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]                          state_reg, state_next;
    logic [ROW_AW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [pfrt_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [pfrt_pkg::ADDR_W-1:0]         first_reg, first_next;
    logic [pfrt_pkg::SHIFT_W-1:0]        shift_reg, shift_next;
    logic [pfrt_pkg::PPF_W-1:0]          ppf_reg, ppf_next;
    logic [PAGE_W-1:0]                   page_reg, page_next;
    logic [PAGE_W-1:0]                   limit_reg, limit_next;
    logic [ROW_AW-1:0]                   spill_row_reg, spill_row_next;
    logic [pfrt_pkg::ROW_BITS-1:0]       mask_hi_reg, mask_hi_next;
    logic [pfrt_pkg::BFLT_W-1:0]         bflt_reg, bflt_next;
    logic [pfrt_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic                                oor_reg, oor_next;

    logic                                wr_en, rd_en;
    logic [ROW_AW-1:0]                   wr_addr, rd_addr;
    logic [pfrt_pkg::ROW_BITS-1:0]       wr_data, rd_data;

    logic [pfrt_pkg::SHIFT_W-1:0]        shift_eff;
    logic [pfrt_pkg::PPF_W-1:0]          ppf_eff;
    logic [pfrt_pkg::SUM_W-1:0]          end_page;
    logic [ROW_AW-1:0]                   cur_row;
    logic [pfrt_pkg::ROW_SEL-1:0]        cur_bit;
    logic [pfrt_pkg::ROW_BITS-1:0]       run_ones;
    logic [2*pfrt_pkg::ROW_BITS-1:0]     run_mask;
    logic [PAGE_W:0]                     run_end;

    pfrt_bitmap #(
        .ROW_AW (ROW_AW)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (page_shift < pfrt_pkg::SHIFT_MIN) begin
            shift_eff = pfrt_pkg::SHIFT_MIN;
        end else if (page_shift > pfrt_pkg::SHIFT_MAX) begin
            shift_eff = pfrt_pkg::SHIFT_MAX;
        end else begin
            shift_eff = page_shift;
        end
        if (pages_per_fault < pfrt_pkg::PPF_MIN) begin
            ppf_eff = pfrt_pkg::PPF_MIN;
        end else if (pages_per_fault > pfrt_pkg::PPF_MAX) begin
            ppf_eff = pfrt_pkg::PPF_MAX;
        end else begin
            ppf_eff = pages_per_fault;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.block_faults = bflt_reg;
    assign res.total_faults = total_reg;
    assign res.out_of_range = oor_reg;

    assign end_page = sum_reg >> shift_reg;
    assign cur_row  = page_reg[PAGE_INDEX_BITS-1:pfrt_pkg::ROW_SEL];
    assign cur_bit  = page_reg[pfrt_pkg::ROW_SEL-1:0];
    // Run of ppf ones placed at the faulting page; the upper half spills into the next row
    assign run_ones = {pfrt_pkg::ROW_BITS{1'b1}} >> (7'(pfrt_pkg::ROW_BITS) - ppf_reg);
    assign run_mask = {{pfrt_pkg::ROW_BITS{1'b0}}, run_ones} << cur_bit;
    assign run_end  = {1'b0, page_reg} + (PAGE_W + 1)'(ppf_reg);

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        sum_next       = sum_reg;
        first_next     = first_reg;
        shift_next     = shift_reg;
        ppf_next       = ppf_reg;
        page_next      = page_reg;
        limit_next     = limit_reg;
        spill_row_next = spill_row_reg;
        mask_hi_next   = mask_hi_reg;
        bflt_next      = bflt_reg;
        total_next     = total_reg;
        oor_next       = oor_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_row;
        wr_data        = rd_data | run_mask[pfrt_pkg::ROW_BITS-1:0];
        rd_en          = 1'b0;
        rd_addr        = cur_row;

        unique case (state_reg)
            S_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    sum_next   = {2'b00, in_start} + {2'b00, in_size}
                               + ((pfrt_pkg::SUM_W'(1) << shift_eff) - 1'b1);
                    first_next = in_start >> shift_eff;
                    shift_next = shift_eff;
                    ppf_next   = ppf_eff;
                    bflt_next  = '0;
                    oor_next   = 1'b0;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (end_page > pfrt_pkg::SUM_W'(MAP_PAGES)) begin
                    limit_next = MAP_PAGES;
                    oor_next   = ({2'b00, first_reg} < end_page);
                end else begin
                    limit_next = end_page[PAGE_W-1:0];
                end
                page_next = first_reg[PAGE_W-1:0];
                if ({2'b00, first_reg} < pfrt_pkg::SUM_W'(limit_next)) begin
                    state_next = S_PROBE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PROBE: begin
                rd_en      = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // The write lands before the next probe is issued, so no bypass is needed
                if (rd_data[cur_bit]) begin
                    page_next = page_reg + 1'b1;
                    state_next = (page_next < limit_reg) ? S_PROBE : S_DONE;
                end else begin
                    wr_en     = 1'b1;
                    bflt_next = bflt_reg + 1'b1;
                    if (total_reg != {pfrt_pkg::TOTAL_W{1'b1}}) begin
                        total_next = total_reg + 1'b1;
                    end
                    if (run_end > (PAGE_W + 1)'(MAP_PAGES)) begin
                        oor_next = 1'b1;
                    end
                    page_next      = run_end[PAGE_W-1:0];
                    spill_row_next = cur_row + 1'b1;
                    mask_hi_next   = run_mask[2*pfrt_pkg::ROW_BITS-1:pfrt_pkg::ROW_BITS];
                    if ((run_mask[2*pfrt_pkg::ROW_BITS-1:pfrt_pkg::ROW_BITS] != '0)
                            && (cur_row != LAST_ROW)) begin
                        state_next = S_SPILL_RD;
                    end else begin
                        state_next = (run_end < (PAGE_W + 1)'(limit_reg)) ? S_PROBE : S_DONE;
                    end
                end
            end
            S_SPILL_RD: begin
                rd_en      = 1'b1;
                rd_addr    = spill_row_reg;
                state_next = S_SPILL_WR;
            end
            S_SPILL_WR: begin
                wr_en      = 1'b1;
                wr_addr    = spill_row_reg;
                wr_data    = rd_data | mask_hi_reg;
                state_next = (page_reg < limit_reg) ? S_PROBE : S_DONE;
            end
            S_DONE: begin
                if (res_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg       <= sum_next;
        first_reg     <= first_next;
        shift_reg     <= shift_next;
        ppf_reg       <= ppf_next;
        page_reg      <= page_next;
        limit_reg     <= limit_next;
        spill_row_reg <= spill_row_next;
        mask_hi_reg   <= mask_hi_next;
        bflt_reg      <= bflt_next;
        oor_reg       <= oor_next;
    end

    // A probe is only issued for a page inside the walk range
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE) |-> (page_reg < limit_reg))
        else $error("probe outside walk range");

    // No bitmap write while waiting for a block
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("bitmap write while idle");

    // A result, once offered, holds until taken
    a_res_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ack) |=> (res_valid && $stable(res)))
        else $error("result dropped before acknowledge");

    // The running total never decreases outside reset
    a_total_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR) |=> (total_reg >= $past(total_reg)))
        else $error("fault total decreased");

endmodule

[hdl/page_fault_residency_tracker.sv]
`timescale 1ns / 1ps
// Top level of the page fault residency tracker: stream ports, configuration
// registers and result register. Uses pfrt_pkg and pfrt_walk (with pfrt_bitmap).
//
// Each input beat names a code block by start address and byte size. The
// tracker walks the pages it covers in ascending order against a residency
// bitmap of 2^PAGE_INDEX_BITS pages held in a RAM of 64-bit rows. A missing
// page counts as one fault and marks itself and the next pages_per_fault - 1
// pages resident; pages past the bitmap are skipped and raise out_of_range.
// One result beat follows each input beat, carrying the block's faults, the
// saturating running total and the range flag. After reset the bitmap is
// cleared one row per cycle, all 2^(PAGE_INDEX_BITS-6) rows (1024 at the
// default), with s_tready held low; configuration writes are taken meanwhile.
// Blocks are handled one at a time: a calculation state, then a read state
// and a check state per probed page, plus a spill read and a spill write
// for each fault whose marked run crosses into the next bitmap row, then a
// done state. The bitmap RAM has one port per direction and reads one row
// per probe. The result sits in an output register, so the next beat is
// accepted while the previous result still waits on m_tready.
// Configuration: index 0 = page_shift (log2 page bytes, clamped to 4..16),
// index 1 = pages_per_fault (clamped to 1..64). Write only while idle.
module page_fault_residency_tracker #(
    parameter int PAGE_INDEX_BITS = pfrt_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [pfrt_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [pfrt_pkg::CFG_DW-1:0]   cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfrt_pkg::IN_TDW-1:0]   s_tdata,  // [31:0] blk_base, [63:32] blk_len
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfrt_pkg::OUT_TDW-1:0]  m_tdata   // [16:0] block_faults,
                                                    // [48:17] total_faults,
                                                    // [49] out_of_range, [55:50] zero
);

    logic [pfrt_pkg::SHIFT_W-1:0] page_shift_reg;
    logic [pfrt_pkg::PPF_W-1:0]   ppf_reg;
    logic                         out_valid_reg, out_valid_next;
    pfrt_pkg::res_t               out_res_reg;
    pfrt_pkg::res_t               walk_res;
    logic                         walk_valid;
    logic                         walk_ack;

    // Configuration registers: hold until written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= pfrt_pkg::SHIFT_RST;
            ppf_reg        <= pfrt_pkg::PPF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pfrt_pkg::CFG_PAGE_SHIFT: page_shift_reg <= cfg_wr_data[pfrt_pkg::SHIFT_W-1:0];
                pfrt_pkg::CFG_PPF:        ppf_reg        <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    pfrt_walk #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_walk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_start        (s_tdata[31:0]),
        .in_size         (s_tdata[63:32]),
        .page_shift      (page_shift_reg),
        .pages_per_fault (ppf_reg),
        .res_valid       (walk_valid),
        .res_ack         (walk_ack),
        .res             (walk_res)
    );

    // Advance a finished result into the output register when it is empty or draining
    assign walk_ack = walk_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (walk_ack) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_ack) begin
            out_res_reg <= walk_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.out_of_range, out_res_reg.total_faults,
                       out_res_reg.block_faults};

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for page_fault_residency_tracker: directed table, then random code blocks.
// Depends on pfrt_pkg and the tracker RTL; carries its own page residency predictor.
module testbench;

    // Bitmap geometry mirrored from the package default
    localparam int      MAP_BITS    = pfrt_pkg::PAGE_INDEX_BITS_DEF;
    localparam longint  MAP_PAGES   = longint'(1) << MAP_BITS;
    localparam int      RES_W       = $bits(pfrt_pkg::res_t);
    // Run shape
    localparam int      PHASES      = 9;
    localparam int      PHASE_ITEMS = 200;
    localparam int      MAX_WALK    = 48;        // cap on in-map pages per random block
    localparam int      SETTLE      = 12;        // quiet cycles before a register write
    localparam int      TAIL        = 40;        // quiet cycles after the last result
    localparam int      DRAIN_LIMIT = 200000;
    localparam longint  CYCLE_LIMIT = 3000000;
    localparam int      LONG_STALL  = 400;

    // Register settings walked by the random phases
    localparam int PH_SHIFT [PHASES] = '{12, 4, 16, 9, 4, 16, 13, 6, 12};
    localparam int PH_PPF   [PHASES] = '{1, 1, 64, 3, 64, 1, 8, 17, 2};

    typedef enum logic [0:0] {ROW_CFG, ROW_BLOCK} row_kind_t;

    // One directed row: a register write (a = index, b = value) or a block
    // (a = start, b = size), with a hand-written result where it is obvious.
    typedef struct packed {
        row_kind_t                    kind;
        logic [31:0]                  a;
        logic [31:0]                  b;
        logic                         typed;
        logic [pfrt_pkg::BFLT_W-1:0]  e_faults;
        logic [pfrt_pkg::TOTAL_W-1:0] e_total;
        logic                         e_oor;
    } dir_row_t;

    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // defaults after reset: 4 KiB pages, one page per fault
        '{ROW_BLOCK, 32'h0000_0000, 32'h0000_0001, 1'b1, 17'd1, 32'd1, 1'b0},
        '{ROW_BLOCK, 32'h0000_0000, 32'h0000_0001, 1'b1, 17'd0, 32'd1, 1'b0},  // now resident
        '{ROW_BLOCK, 32'h0000_2000, 32'h0000_0000, 1'b1, 17'd0, 32'd1, 1'b0},  // empty, aligned
        '{ROW_BLOCK, 32'h0000_3001, 32'h0000_0000, 1'b1, 17'd1, 32'd2, 1'b0},  // empty, unaligned
        '{ROW_BLOCK, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 17'd0, 32'd2, 1'b1},  // past the map
        '{ROW_BLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 17'd0, 32'd2, 1'b1},  // no 32-bit wrap
        '{ROW_BLOCK, 32'h0FFF_F000, 32'h0000_1000, 1'b1, 17'd1, 32'd3, 1'b0},  // last map page
        '{ROW_BLOCK, 32'h0FFF_F000, 32'h0000_2000, 1'b1, 17'd0, 32'd3, 1'b1},  // spills past
        '{ROW_BLOCK, 32'h0000_5000, 32'h0000_3000, 1'b0, 17'd0, 32'd0, 1'b0},
        // both registers below their range
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PAGE_SHIFT), 32'd0,   1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PPF),        32'd0,   1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h0010_0010, 32'h0000_0020, 1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h000F_FFF0, 32'h0000_0010, 1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h0000_0123, 32'h0000_0045, 1'b0, 17'd0, 32'd0, 1'b0},
        // all ones on the write data: both clamp high
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PAGE_SHIFT), 32'h7F,  1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PPF),        32'h7F,  1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'hFFE0_0000, 32'h0000_0001, 1'b0, 17'd0, 32'd0, 1'b0},  // prefetch past
        '{ROW_BLOCK, 32'hFFC0_0000, 32'hFFFF_FFFF, 1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h1234_5678, 32'h0000_0000, 1'b0, 17'd0, 32'd0, 1'b0},
        // just outside the range on each side
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PAGE_SHIFT), 32'd3,   1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PPF),        32'd65,  1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h0003_FF00, 32'h0000_0123, 1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PAGE_SHIFT), 32'd17,  1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_CFG,   32'(pfrt_pkg::CFG_PPF),        32'd64,  1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h0001_0000, 32'h0002_0000, 1'b0, 17'd0, 32'd0, 1'b0},
        '{ROW_BLOCK, 32'h0000_0000, 32'h0000_0000, 1'b0, 17'd0, 32'd0, 1'b0}
    };

    // DUT ports
    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [pfrt_pkg::CFG_AW-1:0]    cfg_addr;
    logic [pfrt_pkg::CFG_DW-1:0]    cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [pfrt_pkg::IN_TDW-1:0]    s_tdata;   // [31:0] blk_base, [63:32] blk_len
    logic                           m_tvalid;
    logic                           m_tready;
    logic [pfrt_pkg::OUT_TDW-1:0]   m_tdata;   // [16:0] block_faults, [48:17] total_faults,
                                               // [49] out_of_range, [55:50] zero

    // Predictor state: its own copy of the map, the total and both registers
    bit                           page_loaded [MAP_PAGES];
    logic [pfrt_pkg::TOTAL_W-1:0] predicted_total;
    logic [pfrt_pkg::SHIFT_W-1:0] shift_reg;
    logic [pfrt_pkg::PPF_W-1:0]   ppf_reg;

    pfrt_pkg::res_t   awaited_results [$];
    // Side info for the beat currently offered: a hand-written result, if any
    bit               cur_typed;
    pfrt_pkg::res_t   cur_exp;

    int     blocks_accepted;
    int     results_checked;
    int     err_count;
    int     faults_seen;
    longint cycle_count;
    bit     idle_on;
    bit     stall_req;

    page_fault_residency_tracker #(
        .PAGE_INDEX_BITS(MAP_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Clamp the registers the way the tracker does
    function automatic int eff_shift();
        if (shift_reg < pfrt_pkg::SHIFT_MIN) return int'(pfrt_pkg::SHIFT_MIN);
        if (shift_reg > pfrt_pkg::SHIFT_MAX) return int'(pfrt_pkg::SHIFT_MAX);
        return int'(shift_reg);
    endfunction

    function automatic int eff_ppf();
        if (ppf_reg < pfrt_pkg::PPF_MIN) return int'(pfrt_pkg::PPF_MIN);
        if (ppf_reg > pfrt_pkg::PPF_MAX) return int'(pfrt_pkg::PPF_MAX);
        return int'(ppf_reg);
    endfunction

    // First page touched and one past the last, in 34 bits so nothing wraps;
    // the end is rounded up even for an empty block.
    function automatic void page_span(input logic [31:0] start, input logic [31:0] size,
                                      output logic [33:0] first, output logic [33:0] stop);
        int sh;
        sh    = eff_shift();
        first = {2'b00, start} >> sh;
        stop  = ({2'b00, start} + {2'b00, size} + ((34'd1 << sh) - 34'd1)) >> sh;
    endfunction

    // Number of pages a block would probe inside the map
    function automatic longint map_pages_walked(input logic [31:0] start,
                                                input logic [31:0] size);
        logic [33:0] first, stop;
        longint      lim;
        page_span(start, size, first, stop);
        lim = (longint'(stop) > MAP_PAGES) ? MAP_PAGES : longint'(stop);
        return (longint'(first) < lim) ? lim - longint'(first) : 0;
    endfunction

    // Walk one block against the predicted map and update it
    function automatic pfrt_pkg::res_t walk_block(input logic [31:0] start,
                                                  input logic [31:0] size);
        logic [33:0]                 first, stop;
        longint                      lim, pg, pf;
        int                          ppf;
        logic [pfrt_pkg::BFLT_W-1:0] faults;
        logic                        oor;
        pfrt_pkg::res_t              r;
        page_span(start, size, first, stop);
        ppf    = eff_ppf();
        faults = '0;
        oor    = 1'b0;
        lim    = longint'(stop);
        if (lim > MAP_PAGES) begin
            lim = MAP_PAGES;
            if (first < stop) oor = 1'b1;
        end
        for (pg = longint'(first); pg < lim; pg++) begin
            if (!page_loaded[pg]) begin
                faults++;
                if (predicted_total != '1) predicted_total++;
                for (pf = pg; pf < pg + ppf; pf++) begin
                    if (pf < MAP_PAGES) page_loaded[pf] = 1'b1;
                    else oor = 1'b1;
                end
            end
        end
        r.block_faults = faults;
        r.total_faults = predicted_total;
        r.out_of_range = oor;
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        if (err_count < 10) $display("MISMATCH cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Cycle counter and run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Sample every handshake at the rising edge: register writes update the
    // predictor, result beats are checked, then input beats are predicted.
    // One process keeps pop and push in a fixed order.
    always @(posedge aclk) begin
        pfrt_pkg::res_t got, want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_addr == pfrt_pkg::CFG_PAGE_SHIFT) begin
                    shift_reg = cfg_wr_data[pfrt_pkg::SHIFT_W-1:0];
                end else if (cfg_addr == pfrt_pkg::CFG_PPF) begin
                    ppf_reg = cfg_wr_data[pfrt_pkg::PPF_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got = pfrt_pkg::res_t'(m_tdata[RES_W-1:0]);
                if (awaited_results.size() == 0) begin
                    log_mismatch($sformatf("stray result: faults %0d total %0d oor %0b",
                                           got.block_faults, got.total_faults,
                                           got.out_of_range));
                end else begin
                    want = awaited_results.pop_front();
                    // fields shown as faults/total/oor
                    if (got.block_faults !== want.block_faults ||
                        got.total_faults !== want.total_faults ||
                        got.out_of_range !== want.out_of_range ||
                        m_tdata[pfrt_pkg::OUT_TDW-1:RES_W] !== '0)
                        log_mismatch($sformatf(
                            "result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b pad %h",
                            results_checked, want.block_faults, want.total_faults,
                            want.out_of_range, got.block_faults, got.total_faults,
                            got.out_of_range, m_tdata[pfrt_pkg::OUT_TDW-1:RES_W]));
                    faults_seen += int'(want.block_faults);
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) begin
                // always run the predictor so the map stays in step
                want = walk_block(s_tdata[31:0], s_tdata[63:32]);
                if (cur_typed) want = cur_exp;
                awaited_results.push_back(want);
                blocks_accepted++;
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_tready = 1'b0;
                repeat (LONG_STALL - 1) @(negedge aclk);
                stall_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one block and hold it until taken; call at a falling edge
    task automatic send_block(input logic [31:0] start, input logic [31:0] size,
                              input bit typed, input pfrt_pkg::res_t exp);
        int target;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tdata   = {size, start};
        cur_typed = typed;
        cur_exp   = exp;
        s_tvalid  = 1'b1;
        target    = blocks_accepted + 1;
        do @(negedge aclk); while (blocks_accepted < target);
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
    endtask

    // Write a register while the tracker is idle
    task automatic write_reg(input logic [pfrt_pkg::CFG_AW-1:0] idx,
                             input logic [pfrt_pkg::CFG_DW-1:0] val);
        drain_results();
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Random block: mostly well-placed starts inside the map with small
    // sizes, plus repeats, blocks at the map edge and raw 32-bit noise.
    task automatic random_block(inout logic [31:0] last_start);
        int             sh, pick;
        logic [31:0]    start, size, mask;
        pfrt_pkg::res_t none;
        none = '0;
        sh   = eff_shift();
        mask = (32'd1 << sh) - 32'd1;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            start = (32'($urandom_range(0, int'(MAP_PAGES) - 1)) << sh) | ($urandom & mask);
        else if (pick < 72)
            start = last_start + ($urandom & mask);
        else if (pick < 84)
            start = (32'($urandom_range(int'(MAP_PAGES) - 8, int'(MAP_PAGES) - 1)) << sh)
                    | ($urandom & mask);
        else
            start = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 15)      size = 32'd0;
        else if (pick < 60) size = 32'($urandom_range(1, 2 << sh));
        else if (pick < 75) size = 32'($urandom_range(1, 4)) << sh;
        else                size = $urandom;
        // keep the walk short; big sizes survive where the start lies past the map
        if (map_pages_walked(start, size) > MAX_WALK)
            size = 32'($urandom_range(0, 3 << sh));
        last_start = start;
        send_block(start, size, 1'b0, none);
    endtask

    initial begin
        logic [31:0]    last_start;
        pfrt_pkg::res_t exp;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wr_data     = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        cur_typed       = 1'b0;
        cur_exp         = '0;
        predicted_total = '0;
        shift_reg       = pfrt_pkg::SHIFT_RST;
        ppf_reg         = pfrt_pkg::PPF_RST;
        idle_on         = 1'b1;
        stall_req       = 1'b0;
        last_start      = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table; the first beat also waits out the bitmap clear
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_CFG) begin
                write_reg(DIR_TABLE[r].a[pfrt_pkg::CFG_AW-1:0],
                          DIR_TABLE[r].b[pfrt_pkg::CFG_DW-1:0]);
            end else begin
                exp.block_faults = DIR_TABLE[r].e_faults;
                exp.total_faults = DIR_TABLE[r].e_total;
                exp.out_of_range = DIR_TABLE[r].e_oor;
                send_block(DIR_TABLE[r].a, DIR_TABLE[r].b, DIR_TABLE[r].typed, exp);
            end
        end

        // Random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(pfrt_pkg::CFG_PAGE_SHIFT, pfrt_pkg::CFG_DW'(PH_SHIFT[ph]));
            write_reg(pfrt_pkg::CFG_PPF, pfrt_pkg::CFG_DW'(PH_PPF[ph]));
            // run the last phase at full rate on both sides
            if (ph == PHASES - 1) idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the receiver off long enough to back the input up
                if (ph == 2 && n == 50) stall_req = 1'b1;
                // pause the sender until the tracker has emptied out
                if (ph == 4 && n == 100) drain_results();
                random_block(last_start);
            end
        end

        s_tvalid = 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && awaited_results.size() != 0; w++)
            @(negedge aclk);
        repeat (TAIL) @(negedge aclk);
        if (awaited_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        $display("testbench: %0d code blocks over %0d register settings, %0d results checked",
                 blocks_accepted, PHASES + 5, results_checked);
        $display("testbench: %0d page faults predicted, %0d mismatches in %0d cycles",
                 faults_seen, err_count, cycle_count);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[files.f]
hdl/pfrt_pkg.sv
hdl/pfrt_bitmap.sv
hdl/pfrt_walk.sv
hdl/page_fault_residency_tracker.sv
tb/testbench.sv
